FILE: src/bpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and register codes of the button press classifier.
// Used by the lane, the merge stage and the top level; depends on nothing.
package bpc_pkg;

    localparam int NUM_BUTTONS  = 8;
    localparam int COUNT_BITS   = 8;
    localparam int PIN_BITS     = 8;
    localparam int IDX_BITS     = 3;
    localparam int REG_BITS     = 8;
    localparam int HOLD_BITS    = 8;
    localparam int CFG_IDX_BITS = 3;
    // Only buttons that have a pin bit get a lane.
    localparam int LANES        = (NUM_BUTTONS < PIN_BITS) ? NUM_BUTTONS : PIN_BITS;
    // Compare width wide enough for both the count and an 8-bit register.
    localparam int CMP_BITS     = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

    localparam int EV_SHORT_BIT = 0;
    localparam int EV_LONG_BIT  = 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS_TICKS = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SHORT_PRESS_MIN  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOFF_TICKS    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUNT_CAP        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BUTTON_ENABLE    = 3'd4;

    localparam logic [REG_BITS-1:0] RST_LONG_PRESS_TICKS = 8'd100;
    localparam logic [REG_BITS-1:0] RST_SHORT_PRESS_MIN  = 8'd3;
    localparam logic [REG_BITS-1:0] RST_HOLDOFF_TICKS    = 8'd10;
    localparam logic [REG_BITS-1:0] RST_COUNT_CAP        = 8'd4;
    localparam logic [REG_BITS-1:0] RST_BUTTON_ENABLE    = 8'd255;

    localparam logic       CMD_TICK = 1'b0;
    localparam logic       CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        PS_IDLE    = 2'd0,
        PS_PRESSED = 2'd1,
        PS_LONG    = 2'd2,
        PS_HOLDOFF = 2'd3
    } press_state_t;

    typedef struct packed {
        logic [REG_BITS-1:0] long_press_ticks;
        logic [REG_BITS-1:0] short_press_min;
        logic [REG_BITS-1:0] holdoff_ticks;
        logic [REG_BITS-1:0] count_cap;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic clear;
        logic pressed;
    } lane_cmd_t;

    typedef struct packed {
        logic       level_now;
        logic       level_next;
        logic [1:0] events;
    } lane_stat_t;

endpackage

FILE: src/button_press_classifier_top.sv
`timescale 1ns / 1ps
// Button press classifier: all buttons update side by side, one lane per button.
// A result appears in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle while the output register is empty or being taken; it frees itself as it drains.
// Reset clears lane state, events and output valid, and loads register defaults.
// Depends on bpc_pkg, bpc_lane and bpc_merge.
module button_press_classifier_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [15:0]                        s_tdata,   // pin_levels[7:0], button_index[10:8]
    input  logic                               s_tuser,   // cmd
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,   // level_mask[7:0], short_press[8], long_press[9]
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [bpc_pkg::REG_BITS-1:0]       cfg_data
);
    import bpc_pkg::*;

    cfg_t                cfg_reg;
    logic [REG_BITS-1:0] enable_reg;
    logic                accept;
    logic                is_read;
    logic [PIN_BITS-1:0] pins;
    logic [IDX_BITS-1:0] idx;
    lane_cmd_t           cmd [LANES];
    lane_stat_t          stat [LANES];
    logic [PIN_BITS-1:0] level_now;
    logic [PIN_BITS-1:0] mask;
    logic                short_press, long_press;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks <= RST_LONG_PRESS_TICKS;
            cfg_reg.short_press_min  <= RST_SHORT_PRESS_MIN;
            cfg_reg.holdoff_ticks    <= RST_HOLDOFF_TICKS;
            cfg_reg.count_cap        <= RST_COUNT_CAP;
            enable_reg               <= RST_BUTTON_ENABLE;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS_TICKS: cfg_reg.long_press_ticks <= cfg_data;
                REG_SHORT_PRESS_MIN:  cfg_reg.short_press_min  <= cfg_data;
                REG_HOLDOFF_TICKS:    cfg_reg.holdoff_ticks    <= cfg_data;
                REG_COUNT_CAP:        cfg_reg.count_cap        <= cfg_data;
                REG_BUTTON_ENABLE:    enable_reg               <= cfg_data;
                default: ;
            endcase
        end
    end

    assign accept  = s_tvalid && s_tready;
    assign is_read = (s_tuser == CMD_READ);
    assign pins    = s_tdata[PIN_BITS-1:0];
    assign idx     = s_tdata[PIN_BITS+IDX_BITS-1:PIN_BITS];

    always_comb
    begin
        level_now = '0;
        for (int i = 0; i < LANES; i++)
        begin
            cmd[i].tick    = accept && (s_tuser == CMD_TICK) && enable_reg[i];
            cmd[i].clear   = accept && is_read && (idx == IDX_BITS'(i));
            cmd[i].pressed = !pins[i];
            level_now[i]   = stat[i].level_now;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        bpc_lane u_lane (
            .clk  (clk),
            .rst_n(rst_n),
            .cfg  (cfg_reg),
            .cmd  (cmd[g]),
            .stat (stat[g])
        );
    end

    bpc_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .is_read    (is_read),
        .idx        (idx),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .in_ready   (s_tready),
        .level_mask (mask),
        .short_press(short_press),
        .long_press (long_press)
    );

    assign m_tdata = {6'b0, long_press, short_press, mask};

`ifndef SYNTHESIS
    // Every accepted request leaves a result in the output register.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted request produced no result");

    // A tick never reports events.
    a_tick_no_events: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_read) |=> (m_tdata[9:8] == 2'b00))
        else $error("tick result carries events");

    // Disabled buttons keep their level across a tick.
    a_disabled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_read) |=>
            (((m_tdata[7:0] ^ $past(level_now)) & ~$past(enable_reg)) == 8'h00))
        else $error("disabled button changed level");

    // A read never changes any level.
    a_read_keeps_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_read) |=> (m_tdata[7:0] == $past(level_now)))
        else $error("read changed a level");
`endif

endmodule

FILE: src/bpc_lane.sv
`timescale 1ns / 1ps
// One button lane: hold-off counter, integrator, debounced level and sticky events.
// Depends on bpc_pkg.
module bpc_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  bpc_pkg::cfg_t      cfg,
    input  bpc_pkg::lane_cmd_t cmd,
    output bpc_pkg::lane_stat_t stat
);
    import bpc_pkg::*;

    press_state_t          state_reg, state_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [HOLD_BITS-1:0]  hold_reg, hold_next;
    logic                  level_reg, level_next;
    logic [1:0]            ev_reg, ev_next;

    logic                  run;
    press_state_t          st;
    logic [CMP_BITS-1:0]   cnt_w, cap_w, before_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PS_IDLE;
            cnt_reg   <= '0;
            hold_reg  <= '0;
            level_reg <= 1'b0;
            ev_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hold_reg  <= hold_next;
            level_reg <= level_next;
            ev_reg    <= ev_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        hold_next  = hold_reg;
        level_next = level_reg;
        ev_next    = ev_reg;
        run        = 1'b0;
        st         = state_reg;
        cnt_w      = '0;
        cap_w      = CMP_BITS'(cfg.count_cap);
        before_w   = CMP_BITS'(cnt_reg);

        if (cmd.clear)
        begin
            ev_next = '0;
        end

        if (cmd.tick)
        begin
            run = 1'b1;
            // A button in hold-off only advances its counter until it expires.
            if (state_reg == PS_HOLDOFF)
            begin
                hold_next = (hold_reg != {HOLD_BITS{1'b1}}) ? hold_reg + 1'b1 : hold_reg;
                if (hold_next > cfg.holdoff_ticks)
                begin
                    st         = PS_IDLE;
                    state_next = PS_IDLE;
                end
                else
                begin
                    run = 1'b0;
                end
            end
        end

        if (run)
        begin
            if (cmd.pressed)
            begin
                if (cnt_reg != {COUNT_BITS{1'b1}})
                    cnt_next = cnt_reg + 1'b1;
            end
            else if (cnt_reg != '0)
            begin
                if (before_w > cap_w)
                    cnt_next = COUNT_BITS'(cfg.count_cap);
                else
                    cnt_next = cnt_reg - 1'b1;
            end

            cnt_w      = CMP_BITS'(cnt_next);
            level_next = (cnt_w >= cap_w);

            if (level_reg && !level_next)
            begin
                if (st == PS_PRESSED && before_w > CMP_BITS'(cfg.short_press_min))
                    ev_next[EV_SHORT_BIT] = 1'b1;
                state_next = PS_HOLDOFF;
                hold_next  = '0;
            end
            else if (!level_reg && level_next)
            begin
                state_next = PS_PRESSED;
            end
            else if (level_reg && level_next)
            begin
                if (cnt_w > CMP_BITS'(cfg.long_press_ticks) && st == PS_PRESSED)
                begin
                    state_next = PS_LONG;
                    ev_next[EV_LONG_BIT] = 1'b1;
                end
            end
        end
    end

    assign stat.level_now  = level_reg;
    assign stat.level_next = level_next;
    assign stat.events     = ev_reg;

endmodule

FILE: src/bpc_merge.sv
`timescale 1ns / 1ps
// Merge stage: gathers the lane levels, selects the events of the read button and
// holds the result in the output register. Depends on bpc_pkg.
module bpc_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          is_read,
    input  logic [bpc_pkg::IDX_BITS-1:0]  idx,
    input  bpc_pkg::lane_stat_t           stat [bpc_pkg::LANES],
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic                          in_ready,
    output logic [bpc_pkg::PIN_BITS-1:0]  level_mask,
    output logic                          short_press,
    output logic                          long_press
);
    import bpc_pkg::*;

    logic                valid_reg, valid_next;
    logic [PIN_BITS-1:0] mask_reg, mask_comb;
    logic                short_reg, long_reg;
    logic [1:0]          ev_sel;

    always_comb
    begin
        mask_comb = '0;
        ev_sel    = '0;
        for (int i = 0; i < LANES; i++)
        begin
            mask_comb[i] = stat[i].level_next;
            if (idx == IDX_BITS'(i))
                ev_sel = stat[i].events;
        end
        if (!is_read)
            ev_sel = '0;
    end

    // The register frees itself when the result is taken, so a new request can
    // enter in the same cycle.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mask_reg  <= mask_comb;
            short_reg <= ev_sel[EV_SHORT_BIT];
            long_reg  <= ev_sel[EV_LONG_BIT];
        end
    end

    assign out_valid   = valid_reg;
    assign level_mask  = mask_reg;
    assign short_press = short_reg;
    assign long_press  = long_reg;

endmodule

FILE: tb/tb_button_press_classifier_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_press_classifier_top: a directed table, then
// randomized press and release sequences, checked against an in-bench model of the
// debounce, hold-off and event logic. Depends on bpc_pkg and the RTL of the block.
module tb_button_press_classifier_top;

    import bpc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [PIN_BITS-1:0] level_mask;
        logic                short_press;
        logic                long_press;
    } press_result_t;

    typedef enum logic { ROW_REQ, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic                     cmd;
        logic [PIN_BITS-1:0]      pins;
        logic [IDX_BITS-1:0]      idx;
        bit                       known;
        press_result_t            want;
        logic [CFG_IDX_BITS-1:0]  reg_idx;
        logic [REG_BITS-1:0]      value;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [15:0]              s_tdata = '0;   // pin_levels[7:0], button_index[10:8]
    logic                     s_tuser = 1'b0; // cmd
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [15:0]              m_tdata;        // level_mask[7:0], short_press[8], long_press[9]
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [REG_BITS-1:0]      cfg_data = '0;

    // Model copy of the registers and of every button's state.
    logic [REG_BITS-1:0]      cfg_long;
    logic [REG_BITS-1:0]      cfg_short_min;
    logic [REG_BITS-1:0]      cfg_holdoff;
    logic [REG_BITS-1:0]      cfg_cap;
    logic [REG_BITS-1:0]      cfg_enable;
    press_state_t             btn_state  [LANES];
    logic [COUNT_BITS-1:0]    btn_count  [LANES];
    logic [HOLD_BITS-1:0]     btn_hold   [LANES];
    logic                     btn_level  [LANES];
    logic [1:0]               btn_events [LANES];

    press_result_t            pending_results [$];
    stim_row_t                directed_rows [$];

    // Random press pattern per button: the level it is held at and for how many ticks.
    bit                       want_press [PIN_BITS];
    int                       hold_left  [PIN_BITS];

    int  errors = 0;
    int  cycle_count = 0;
    int  req_count = 0;
    int  read_count = 0;
    int  results_seen = 0;
    int  short_seen = 0;
    int  long_seen = 0;
    int  reg_writes = 0;
    bit  send_burst = 1'b0;
    bit  recv_burst = 1'b0;
    bit  pressure_done = 1'b0;

    button_press_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void note_failure(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
    endfunction

    // Applies one request to the model and returns the result it must produce.
    function automatic press_result_t classify_request(input logic cmd,
                                                       input logic [PIN_BITS-1:0] pins,
                                                       input logic [IDX_BITS-1:0] idx);
        press_result_t          res;
        logic [COUNT_BITS-1:0]  cnt_prior;
        logic [COUNT_BITS-1:0]  cnt;
        logic                   now_level;
        bit                     live;
        int                     b;
        res = '0;
        if (cmd == CMD_TICK)
        begin
            for (b = 0; b < LANES; b++)
            begin
                live = cfg_enable[b];
                if (live && btn_state[b] == PS_HOLDOFF)
                begin
                    if (btn_hold[b] != {HOLD_BITS{1'b1}})
                    begin
                        btn_hold[b]++;
                    end
                    if (btn_hold[b] > cfg_holdoff)
                    begin
                        btn_state[b] = PS_IDLE;
                    end
                    else
                    begin
                        live = 1'b0;
                    end
                end
                if (live)
                begin
                    cnt_prior = btn_count[b];
                    cnt = cnt_prior;
                    if (!pins[b])
                    begin
                        if (cnt != {COUNT_BITS{1'b1}})
                        begin
                            cnt++;
                        end
                    end
                    else if (cnt != 0)
                    begin
                        // A release from above the cap snaps straight down to it.
                        cnt = (cnt > cfg_cap) ? cfg_cap : cnt - 1'b1;
                    end
                    btn_count[b] = cnt;
                    now_level = (cnt >= cfg_cap);
                    if (btn_level[b] && !now_level)
                    begin
                        if (btn_state[b] == PS_PRESSED && cnt_prior > cfg_short_min)
                        begin
                            btn_events[b][EV_SHORT_BIT] = 1'b1;
                        end
                        btn_state[b] = PS_HOLDOFF;
                        btn_hold[b] = '0;
                    end
                    else if (!btn_level[b] && now_level)
                    begin
                        btn_state[b] = PS_PRESSED;
                    end
                    else if (btn_level[b] && now_level)
                    begin
                        if (cnt > cfg_long && btn_state[b] == PS_PRESSED)
                        begin
                            btn_state[b] = PS_LONG;
                            btn_events[b][EV_LONG_BIT] = 1'b1;
                        end
                    end
                    btn_level[b] = now_level;
                end
            end
        end
        else if (idx < LANES)
        begin
            res.short_press = btn_events[idx][EV_SHORT_BIT];
            res.long_press  = btn_events[idx][EV_LONG_BIT];
            btn_events[idx] = '0;
        end
        for (b = 0; b < LANES; b++)
        begin
            res.level_mask[b] = btn_level[b];
        end
        return res;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_BITS-1:0] r,
                                           input logic [REG_BITS-1:0] v);
        case (r)
            REG_LONG_PRESS_TICKS: cfg_long = v;
            REG_SHORT_PRESS_MIN:  cfg_short_min = v;
            REG_HOLDOFF_TICKS:    cfg_holdoff = v;
            REG_COUNT_CAP:        cfg_cap = v;
            REG_BUTTON_ENABLE:    cfg_enable = v;
            default:              ;
        endcase
    endfunction

    // Pin pattern for the next tick: mostly held levels of random length, with some
    // contact bounce and the odd tick of pure noise.
    function automatic logic [PIN_BITS-1:0] next_pins();
        logic [PIN_BITS-1:0] p;
        int                  b;
        int                  r;
        int                  cap_i;
        p = '1;
        if ($urandom_range(0, 99) < 8)
        begin
            p = PIN_BITS'($urandom_range(0, 255));
        end
        else
        begin
            cap_i = int'(cfg_cap);
            for (b = 0; b < PIN_BITS; b++)
            begin
                if (hold_left[b] == 0)
                begin
                    want_press[b] = !want_press[b];
                    r = $urandom_range(0, 99);
                    if (!want_press[b])
                    begin
                        hold_left[b] = (r < 60) ? $urandom_range(1, 8)
                                                : $urandom_range(1, int'(cfg_holdoff) + 6);
                    end
                    else if (r < 50)
                    begin
                        hold_left[b] = $urandom_range(1, cap_i + int'(cfg_short_min) + 3);
                    end
                    else if (r < 85)
                    begin
                        hold_left[b] = $urandom_range(cap_i + 1, cap_i + int'(cfg_long) + 10);
                    end
                    else
                    begin
                        hold_left[b] = $urandom_range(200, 320);
                    end
                end
                hold_left[b]--;
                p[b] = !want_press[b];
                if ($urandom_range(0, 39) == 0)
                begin
                    p[b] = !p[b];
                end
            end
        end
        return p;
    endfunction

    function automatic stim_row_t req_row(input logic cmd, input logic [PIN_BITS-1:0] pins,
                                          input logic [IDX_BITS-1:0] idx);
        stim_row_t row;
        row = '{kind: ROW_REQ, cmd: cmd, pins: pins, idx: idx, known: 1'b0, want: '0,
                reg_idx: '0, value: '0};
        return row;
    endfunction

    function automatic stim_row_t known_row(input logic cmd, input logic [PIN_BITS-1:0] pins,
                                            input logic [IDX_BITS-1:0] idx,
                                            input logic [PIN_BITS-1:0] level,
                                            input logic sp, input logic lp);
        stim_row_t row;
        row = req_row(cmd, pins, idx);
        row.known = 1'b1;
        row.want = '{level_mask: level, short_press: sp, long_press: lp};
        return row;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_BITS-1:0] r,
                                          input logic [REG_BITS-1:0] v);
        stim_row_t row;
        row = '{kind: ROW_REG, cmd: CMD_TICK, pins: '0, idx: '0, known: 1'b0, want: '0,
                reg_idx: r, value: v};
        return row;
    endfunction

    task automatic send_req(input logic cmd, input logic [PIN_BITS-1:0] pins,
                            input logic [IDX_BITS-1:0] idx, input bit known,
                            input press_result_t want);
        int            gap;
        press_result_t pred;
        @(negedge clk);
        gap = send_burst ? 0 : $urandom_range(0, 12);
        if ($urandom_range(0, 39) == 0)
        begin
            send_burst = !send_burst;
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'b0, idx, pins};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        pred = classify_request(cmd, pins, idx);
        pending_results.push_back(known ? want : pred);
        req_count++;
        if (cmd == CMD_READ)
        begin
            read_count++;
        end
    endtask

    // Registers change only with nothing in flight.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] r, input logic [REG_BITS-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_register(r, v);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [REG_BITS-1:0] long_v, input logic [REG_BITS-1:0] short_v,
                            input logic [REG_BITS-1:0] hold_v, input logic [REG_BITS-1:0] cap_v,
                            input logic [REG_BITS-1:0] en_v);
        wait_idle();
        write_reg(REG_LONG_PRESS_TICKS, long_v);
        write_reg(REG_SHORT_PRESS_MIN, short_v);
        write_reg(REG_HOLDOFF_TICKS, hold_v);
        write_reg(REG_COUNT_CAP, cap_v);
        write_reg(REG_BUTTON_ENABLE, en_v);
    endtask

    task automatic run_phase(input int n_req, input int read_pct);
        int k;
        for (k = 0; k < n_req; k++)
        begin
            if ($urandom_range(0, 99) < read_pct)
            begin
                send_req(CMD_READ, PIN_BITS'($urandom_range(0, 255)),
                         IDX_BITS'($urandom_range(0, 7)), 1'b0, '0);
            end
            else
            begin
                send_req(CMD_TICK, next_pins(), IDX_BITS'($urandom_range(0, 7)), 1'b0, '0);
            end
        end
    endtask

    // Result sink with random stalls, plus one long hold-off that backs the block up.
    initial
    begin : result_sink
        int n;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && results_seen >= 500)
            begin
                n = 150;
                pressure_done = 1'b1;
            end
            else
            begin
                n = recv_burst ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 39) == 0)
                begin
                    recv_burst = !recv_burst;
                end
            end
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        press_result_t got;
        press_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{level_mask: m_tdata[7:0], short_press: m_tdata[8], long_press: m_tdata[9]};
            results_seen++;
            short_seen += int'(got.short_press);
            long_seen  += int'(got.long_press);
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("result with no request pending: level %02h sp %0b lp %0b",
                                       got.level_mask, got.short_press, got.long_press));
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got.level_mask !== exp.level_mask || got.short_press !== exp.short_press ||
                    got.long_press !== exp.long_press)
                begin
                    note_failure($sformatf(
                        "result %0d: level %02h/%02h sp %0b/%0b lp %0b/%0b (expected/actual)",
                        results_seen, exp.level_mask, got.level_mask, exp.short_press,
                        got.short_press, exp.long_press, got.long_press));
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** button_press_classifier_top: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        int spins;
        cfg_long      = RST_LONG_PRESS_TICKS;
        cfg_short_min = RST_SHORT_PRESS_MIN;
        cfg_holdoff   = RST_HOLDOFF_TICKS;
        cfg_cap       = RST_COUNT_CAP;
        cfg_enable    = RST_BUTTON_ENABLE;
        for (i = 0; i < LANES; i++)
        begin
            btn_state[i]  = PS_IDLE;
            btn_count[i]  = '0;
            btn_hold[i]   = '0;
            btn_level[i]  = 1'b0;
            btn_events[i] = '0;
        end

        // Right after reset: reads see nothing, and all buttons press together until
        // the count reaches the default cap of four.
        directed_rows.push_back(known_row(CMD_READ, 8'hFF, 3'd0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(known_row(CMD_READ, 8'h00, 3'd7, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(known_row(CMD_TICK, 8'hFF, 3'd7, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(known_row(CMD_TICK, 8'h00, 3'd0, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(known_row(CMD_TICK, 8'h00, 3'd5, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(known_row(CMD_TICK, 8'h00, 3'd2, 8'h00, 1'b0, 1'b0));
        directed_rows.push_back(known_row(CMD_TICK, 8'h00, 3'd7, 8'hFF, 1'b0, 1'b0));
        // Lower four release into a short press; reads of button 4 see none, a read of button 0 finds it.
        directed_rows.push_back(req_row(CMD_TICK, 8'hF0 ^ 8'hFF, 3'd1));
        directed_rows.push_back(req_row(CMD_READ, 8'h5A, 3'd4));
        directed_rows.push_back(req_row(CMD_READ, 8'hA5, 3'd4));
        directed_rows.push_back(req_row(CMD_READ, 8'h00, 3'd0));
        // Low extremes: a long-press threshold of one, no hold-off at all.
        directed_rows.push_back(reg_row(REG_LONG_PRESS_TICKS, 8'd1));
        directed_rows.push_back(reg_row(REG_SHORT_PRESS_MIN, 8'd0));
        directed_rows.push_back(reg_row(REG_HOLDOFF_TICKS, 8'd0));
        directed_rows.push_back(reg_row(REG_COUNT_CAP, 8'd1));
        directed_rows.push_back(req_row(CMD_TICK, 8'hF0, 3'd6));
        directed_rows.push_back(req_row(CMD_TICK, 8'hFF, 3'd3));
        directed_rows.push_back(req_row(CMD_READ, 8'hFF, 3'd1));
        directed_rows.push_back(req_row(CMD_READ, 8'h00, 3'd5));
        // Zero cap keeps every enabled button at the pressed level; half the buttons disabled.
        directed_rows.push_back(reg_row(REG_COUNT_CAP, 8'd0));
        directed_rows.push_back(reg_row(REG_BUTTON_ENABLE, 8'h55));
        directed_rows.push_back(req_row(CMD_TICK, 8'hAA, 3'd0));
        directed_rows.push_back(req_row(CMD_TICK, 8'h00, 3'd4));
        directed_rows.push_back(req_row(CMD_READ, 8'hC3, 3'd2));
        // High extremes, with a hold-off that never ends.
        directed_rows.push_back(reg_row(REG_HOLDOFF_TICKS, 8'd255));
        directed_rows.push_back(reg_row(REG_COUNT_CAP, 8'd2));
        directed_rows.push_back(reg_row(REG_BUTTON_ENABLE, 8'hFF));
        directed_rows.push_back(reg_row(REG_LONG_PRESS_TICKS, 8'd254));
        directed_rows.push_back(reg_row(REG_SHORT_PRESS_MIN, 8'd254));
        directed_rows.push_back(req_row(CMD_TICK, 8'h00, 3'd1));
        directed_rows.push_back(req_row(CMD_TICK, 8'h00, 3'd2));
        directed_rows.push_back(req_row(CMD_TICK, 8'hFF, 3'd3));
        directed_rows.push_back(req_row(CMD_TICK, 8'h00, 3'd4));
        directed_rows.push_back(req_row(CMD_READ, 8'h0F, 3'd3));
        directed_rows.push_back(req_row(CMD_TICK, 8'h00, 3'd5));

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            end
            else
            begin
                send_req(directed_rows[i].cmd, directed_rows[i].pins, directed_rows[i].idx,
                         directed_rows[i].known, directed_rows[i].want);
            end
        end

        set_regs(RST_LONG_PRESS_TICKS, RST_SHORT_PRESS_MIN, RST_HOLDOFF_TICKS,
                 RST_COUNT_CAP, RST_BUTTON_ENABLE);
        run_phase(150, 20);
        set_regs(8'd1, 8'd0, 8'd0, 8'd1, 8'hFF);
        run_phase(150, 25);
        // Large thresholds with few reads so that long holds saturate the integrator.
        set_regs(8'd254, 8'd254, 8'd254, 8'd254, 8'hFF);
        run_phase(330, 5);
        set_regs(8'd5, 8'd2, 8'd0, 8'd0, 8'hA5);
        run_phase(100, 20);
        set_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'h00);
        run_phase(100, 20);
        set_regs(8'd12, 8'd2, 8'd255, 8'd3, 8'hFF);
        run_phase(120, 20);
        repeat (2)
        begin
            set_regs(REG_BITS'($urandom_range(1, 60)), REG_BITS'($urandom_range(0, 10)),
                     REG_BITS'($urandom_range(0, 20)), REG_BITS'($urandom_range(1, 12)),
                     REG_BITS'($urandom_range(0, 255)));
            run_phase(150, 20);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        spins = 0;
        while (pending_results.size() != 0 && spins < 5000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            note_failure($sformatf("%0d expected results never arrived", pending_results.size()));
        end

        $display("Run covered %0d requests (%0d reads), %0d register writes, %0d results.",
                 req_count, read_count, reg_writes, results_seen);
        $display("Results carried %0d short and %0d long presses; %0d failures found.",
                 short_seen, long_seen, errors);
        if (errors == 0)
        begin
            $display("** button_press_classifier_top: PASSED **");
        end
        else
        begin
            $display("** button_press_classifier_top: FAILED **");
        end
        $finish;
    end

endmodule
